// ===== rtl/tdsr_pkg.sv =====
// Shared types, constants and saturation limits for the tridiagonal reduction block.
package tdsr_pkg;

    localparam int COEF_W       = 32;
    localparam int FRAC_W       = 16;
    localparam int NUM_W        = COEF_W + FRAC_W;
    localparam int CFG_W        = 7;
    localparam int DEF_MAX_ROWS = 64;
    localparam logic [CFG_W-1:0] DEF_ROW_COUNT = CFG_W'(64);

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

    typedef logic signed [COEF_W-1:0] t_coef;

    // One stored row: lower, diagonal, upper, right side
    typedef logic [3:0][COEF_W-1:0] t_row;

    typedef struct packed {
        logic signed [31:0] row_lower;
        logic signed [31:0] row_diag;
        logic signed [31:0] row_upper;
        logic signed [31:0] row_rhs;
    } t_in_row;

    typedef struct packed {
        logic signed [31:0] out_lower;
        logic signed [31:0] out_diag;
        logic signed [31:0] out_upper;
        logic signed [31:0] out_rhs;
        logic               last_row;
        logic               divide_fault;
    } t_out_row;

    // Saturated value with its overflow flag
    typedef struct packed {
        t_coef val;
        logic  ovf;
    } t_sat;

    typedef struct packed {
        logic  start;
        t_coef num;
        t_coef den;
    } t_div_req;

    typedef struct packed {
        logic done;
        t_sat res;
    } t_div_rsp;

endpackage

// ===== rtl/tdsr_row_mem.sv =====
// Row store: one write port and one registered read port.
module tdsr_row_mem
    import tdsr_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ROWS
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  t_row                     i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output t_row                     o_rdata
);

    t_row r_mem [DEPTH];
    t_row r_rdata;

    // Write the addressed row
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tdsr_mul.sv =====
// Q16.16 multiplier: registered product, floor shift and saturation.
module tdsr_mul
    import tdsr_pkg::*;
(
    input  logic  i_clk,
    input  t_coef i_a,
    input  t_coef i_b,
    output t_sat  o_res
);

    logic signed [2*COEF_W-1:0]      r_prod;
    logic signed [2*COEF_W-FRAC_W-1:0] shifted;
    logic [2*COEF_W-FRAC_W-COEF_W:0]   top_bits;

    // Register the full product
    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    // Drop the fraction bits (rounds toward minus infinity) and saturate
    always_comb begin
        shifted  = r_prod[2*COEF_W-1:FRAC_W];
        top_bits = shifted[2*COEF_W-FRAC_W-1:COEF_W-1];
        o_res.ovf = !((&top_bits) || !(|top_bits));
        if (o_res.ovf) begin
            o_res.val = shifted[2*COEF_W-FRAC_W-1] ? COEF_MIN : COEF_MAX;
        end else begin
            o_res.val = shifted[COEF_W-1:0];
        end
    end

endmodule

// ===== rtl/tdsr_div.sv =====
// Iterative divider for the elimination factor -(x * 2^16) / y, two quotient bits per cycle.
module tdsr_div
    import tdsr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int STEPS = NUM_W / 2;
    localparam int SC_W  = $clog2(STEPS);

    logic              r_busy;
    logic [SC_W-1:0]   r_cnt;
    logic [NUM_W-1:0]  r_quo;
    logic [COEF_W-1:0] r_rem;
    logic [COEF_W-1:0] r_dvs;
    logic              r_neg;
    t_div_rsp          r_rsp;

    logic [NUM_W-1:0]  quo_nx;
    logic [COEF_W-1:0] rem_nx;
    logic [COEF_W:0]   trial;
    logic [COEF_W-1:0] num_mag;
    logic [COEF_W-1:0] den_mag;
    logic              big;
    t_sat              fin;

    assign num_mag = i_req.num[COEF_W-1] ? COEF_W'(-i_req.num) : i_req.num;
    assign den_mag = i_req.den[COEF_W-1] ? COEF_W'(-i_req.den) : i_req.den;

    // Two restoring steps per cycle
    always_comb begin
        quo_nx = r_quo;
        rem_nx = r_rem;
        trial  = '0;
        for (int s = 0; s < 2; s++) begin
            trial  = {rem_nx, quo_nx[NUM_W-1]};
            quo_nx = {quo_nx[NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, r_dvs}) begin
                trial     = trial - {1'b0, r_dvs};
                quo_nx[0] = 1'b1;
            end
            rem_nx = trial[COEF_W-1:0];
        end
    end

    // Apply the sign and saturate the final magnitude
    always_comb begin
        big = |quo_nx[NUM_W-1:COEF_W-1];
        if (r_neg) begin
            fin.ovf = big;
            fin.val = big ? COEF_MAX : quo_nx[COEF_W-1:0];
        end else begin
            fin.ovf = big && (quo_nx != NUM_W'(COEF_MIN[COEF_W-1:0]));
            fin.val = fin.ovf ? COEF_MIN : COEF_W'(-quo_nx[COEF_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_rsp     <= '0;
            r_cnt     <= '0;
        end else begin
            r_rsp.done <= 1'b0;
            if (i_req.start) begin
                if (i_req.den == '0) begin
                    // Zero divisor: flag it and saturate by the sign of x; a zero x gives zero
                    r_rsp.done    <= 1'b1;
                    r_rsp.res.ovf <= 1'b1;
                    if (i_req.num == '0) begin
                        r_rsp.res.val <= '0;
                    end else begin
                        r_rsp.res.val <= i_req.num[COEF_W-1] ? COEF_MAX : COEF_MIN;
                    end
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= '0;
                    r_quo  <= {num_mag, {FRAC_W{1'b0}}};
                    r_rem  <= '0;
                    r_dvs  <= den_mag;
                    r_neg  <= i_req.num[COEF_W-1] ^ i_req.den[COEF_W-1];
                end
            end else if (r_busy) begin
                r_quo <= quo_nx;
                r_rem <= rem_nx;
                r_cnt <= r_cnt + SC_W'(1);
                if (r_cnt == SC_W'(STEPS - 1)) begin
                    r_busy     <= 1'b0;
                    r_rsp.done <= 1'b1;
                    r_rsp.res  <= fin;
                end
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== rtl/tridiagonal_two_sweep_reduction.sv =====
// Top level: row loading, the two elimination sweeps and row emission.
//
// Loads row_count rows (clamped to 1..MAX_ROWS, one per input transfer), then runs a
// forward sweep over rows 3..n and a backward sweep over rows n-2..1, each row
// step reading the pivot and target rows from the row store, computing the
// factor in the shared divider (two quotient bits per cycle) and applying it
// through the shared multiplier in three passes: 2*(n-2) steps for n of three
// or more. The n rows then leave in order, each held while the output side
// stalls. The input side is stalled from the last row of a run until the final
// row of that run has been transferred out. No clearing pass after reset.
module tridiagonal_two_sweep_reduction
    import tdsr_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_row          i_in_row,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_row         o_out_row
);

    localparam int AW = $clog2(MAX_ROWS);
    localparam int CW = $clog2(MAX_ROWS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_RD_PIV, S_RD_TGT, S_DIV_GO, S_DIV, S_MUL, S_WR,
        S_EMIT_RD, S_EMIT_LD, S_EMIT_HOLD
    } t_state;

    typedef enum logic [1:0] {
        FLD_LOWER = 2'd3, FLD_DIAG = 2'd2, FLD_UPPER = 2'd1, FLD_RHS = 2'd0
    } t_fld;

    t_state           r_state;
    logic [CFG_W-1:0] r_row_count;
    logic [CW-1:0]    r_loaded;
    logic [CW-1:0]    r_n;
    logic [AW-1:0]    r_j;
    logic [AW-1:0]    r_k;
    logic             r_bwd;
    logic             r_fault;
    logic [1:0]       r_mc;
    t_row             r_piv;
    t_row             r_tgt;
    t_coef            r_f;
    logic             r_out_valid;
    t_out_row         r_out;

    logic [CW-1:0]    n_eff;
    logic [CW-1:0]    n_loaded;
    logic             in_acc;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    t_row             mem_wdata;
    t_row             in_word;
    logic [AW-1:0]    mem_raddr;
    t_row             mem_rdata;
    logic [AW-1:0]    piv_addr;
    t_div_req         div_req;
    t_div_rsp         div_rsp;
    t_coef            mul_b;
    t_sat             mul_res;
    logic [1:0]       use_idx;
    t_fld             dst;
    t_sat             add_res;

    // Pivot field multiplied in pass k
    function automatic t_fld src_fld(input logic bwd, input logic [1:0] k);
        case (k)
            2'd0:    src_fld = bwd ? FLD_UPPER : FLD_LOWER;
            2'd1:    src_fld = bwd ? FLD_RHS : FLD_UPPER;
            default: src_fld = bwd ? FLD_LOWER : FLD_RHS;
        endcase
    endfunction

    // Target field updated by pass k
    function automatic t_fld dst_fld(input logic bwd, input logic j0, input logic [1:0] k);
        case (k)
            2'd0:    dst_fld = bwd ? FLD_UPPER : FLD_LOWER;
            2'd1:    dst_fld = bwd ? FLD_RHS : FLD_DIAG;
            default: dst_fld = bwd ? (j0 ? FLD_DIAG : FLD_LOWER) : FLD_RHS;
        endcase
    endfunction

    function automatic t_sat sat_add(input t_coef a, input t_coef b);
        logic [COEF_W:0] sum;
        sum = {a[COEF_W-1], a} + {b[COEF_W-1], b};
        sat_add.ovf = sum[COEF_W] != sum[COEF_W-1];
        if (sat_add.ovf) begin
            sat_add.val = sum[COEF_W] ? COEF_MIN : COEF_MAX;
        end else begin
            sat_add.val = sum[COEF_W-1:0];
        end
    endfunction

    // Clamp the row count to 1..MAX_ROWS
    always_comb begin
        if (r_row_count == '0) begin
            n_eff = CW'(1);
        end else if ({1'b0, r_row_count} > (CFG_W + 1)'(MAX_ROWS)) begin
            n_eff = CW'(MAX_ROWS);
        end else begin
            n_eff = CW'(r_row_count);
        end
    end

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign n_loaded = r_loaded + CW'(1);
    assign piv_addr = r_bwd ? (r_j + AW'(1)) : (r_j - AW'(1));

    always_comb begin
        in_word            = '0;
        in_word[FLD_LOWER] = i_in_row.row_lower;
        in_word[FLD_DIAG]  = i_in_row.row_diag;
        in_word[FLD_UPPER] = i_in_row.row_upper;
        in_word[FLD_RHS]   = i_in_row.row_rhs;
    end

    // Store port selection: loads in idle, write-back after a step
    assign mem_we    = in_acc || (r_state == S_WR);
    assign mem_waddr = in_acc ? r_loaded[AW-1:0] : r_j;
    assign mem_wdata = in_acc ? in_word : r_tgt;

    always_comb begin
        case (r_state)
            S_RD_PIV: mem_raddr = piv_addr;
            S_RD_TGT: mem_raddr = r_j;
            default:  mem_raddr = r_k;
        endcase
    end

    // Factor request straight from the target read data
    always_comb begin
        div_req.start = (r_state == S_DIV_GO);
        div_req.num   = r_bwd ? mem_rdata[FLD_UPPER] : mem_rdata[FLD_LOWER];
        div_req.den   = r_piv[FLD_DIAG];
    end

    assign mul_b   = r_piv[src_fld(r_bwd, r_mc)];
    assign use_idx = r_mc - 2'd1;
    assign dst     = dst_fld(r_bwd, r_j == '0, use_idx);
    assign add_res = sat_add(r_tgt[dst], mul_res.val);

    tdsr_row_mem #(.DEPTH(MAX_ROWS)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    tdsr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    tdsr_mul u_mul (
        .i_clk (i_clk),
        .i_a   (r_f),
        .i_b   (mul_b),
        .o_res (mul_res)
    );

    // Sequencer: load, sweep, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= DEF_ROW_COUNT;
            r_loaded    <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
            r_bwd       <= 1'b0;
            r_j         <= '0;
            r_k         <= '0;
            r_mc        <= '0;
            r_n         <= '0;
        end else begin
            if (i_cfg_we) begin
                r_row_count <= i_cfg_data;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (n_loaded >= n_eff) begin
                            r_loaded <= '0;
                            r_n      <= n_eff;
                            r_k      <= '0;
                            if (n_eff >= CW'(3)) begin
                                r_bwd   <= 1'b0;
                                r_j     <= AW'(2);
                                r_state <= S_RD_PIV;
                            end else begin
                                r_state <= S_EMIT_RD;
                            end
                        end else begin
                            r_loaded <= n_loaded;
                        end
                    end
                end
                S_RD_PIV: begin
                    r_state <= S_RD_TGT;
                end
                S_RD_TGT: begin
                    r_piv   <= mem_rdata;
                    r_state <= S_DIV_GO;
                end
                S_DIV_GO: begin
                    r_tgt   <= mem_rdata;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_f     <= div_rsp.res.val;
                        r_fault <= r_fault | div_rsp.res.ovf;
                        r_mc    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    // Issue pass r_mc, fold in the product of the pass before
                    if (r_mc != 2'd0) begin
                        if (use_idx == 2'd0) begin
                            r_tgt[dst] <= mul_res.val;
                            r_fault    <= r_fault | mul_res.ovf;
                        end else begin
                            r_tgt[dst] <= add_res.val;
                            r_fault    <= r_fault | mul_res.ovf | add_res.ovf;
                        end
                    end
                    r_mc <= r_mc + 2'd1;
                    if (r_mc == 2'd3) begin
                        r_state <= S_WR;
                    end
                end
                S_WR: begin
                    r_state <= S_RD_PIV;
                    if (!r_bwd) begin
                        if (CW'(r_j) == r_n - CW'(1)) begin
                            r_bwd <= 1'b1;
                            r_j   <= AW'(r_n - CW'(3));
                        end else begin
                            r_j <= r_j + AW'(1);
                        end
                    end else if (r_j == '0) begin
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_j <= r_j - AW'(1);
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT_LD;
                end
                S_EMIT_LD: begin
                    r_out.out_lower    <= mem_rdata[FLD_LOWER];
                    r_out.out_diag     <= mem_rdata[FLD_DIAG];
                    r_out.out_upper    <= mem_rdata[FLD_UPPER];
                    r_out.out_rhs      <= mem_rdata[FLD_RHS];
                    r_out.last_row     <= (CW'(r_k) + CW'(1)) == r_n;
                    r_out.divide_fault <= r_fault;
                    r_out_valid        <= 1'b1;
                    r_state            <= S_EMIT_HOLD;
                end
                S_EMIT_HOLD: begin
                    // Hold the row until it is transferred
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        if (r_out.last_row) begin
                            r_fault <= 1'b0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + AW'(1);
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out;

    // A pending result always blocks new input
    a_out_blocks_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input open while a result is pending");

    // The final row of a run reopens the input side
    a_last_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_row.last_row) |=> !o_in_stall)
        else $error("input not reopened after the final row");

    // The load count always stays below MAX_ROWS
    a_loaded_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_loaded < CW'(MAX_ROWS))
        else $error("load count out of range");

    // Sweep steps stay inside the run
    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (CW'(r_j) < r_n))
        else $error("sweep step outside the run");

endmodule

// ===== verif/tridiagonal_two_sweep_reduction_test.sv =====
// Testbench for the tridiagonal two-sweep partition reduction block.
`timescale 1ns / 100ps

module tridiagonal_two_sweep_reduction_test;
    import tdsr_pkg::*;

    localparam int  CYCLE_LIMIT = 2000000;
    localparam int  HOLD_CYCLES = 700;
    localparam int  ROWS_MAX    = 64;
    localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
    localparam logic signed [63:0] SAT_LO = -64'sd2147483648;
    localparam logic signed [31:0] ONE_Q  = 32'sh0001_0000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;
    logic             i_in_valid;
    logic             o_in_stall;
    t_in_row          i_in_row;
    logic             o_out_valid;
    logic             i_out_stall;
    t_out_row         o_out_row;

    tridiagonal_two_sweep_reduction dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_row    (i_in_row),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_row   (o_out_row)
    );

    // Predictor state: row store, load count, fault flag and row count
    logic signed [63:0] lower_rows [ROWS_MAX];
    logic signed [63:0] diag_rows  [ROWS_MAX];
    logic signed [63:0] upper_rows [ROWS_MAX];
    logic signed [63:0] rhs_rows   [ROWS_MAX];
    int                 loaded_rows;
    logic               run_fault;
    int                 rows_per_run;

    t_out_row reduced_rows_due[$];
    int       mismatches;
    int       rows_checked;
    int       rows_sent;
    int       runs_done;
    int       cycle_count = 0;
    bit       quiet;
    int       hold_seq;

    // Clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d rows still due", cycle_count,
                     reduced_rows_due.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic signed [63:0] clamp_q(input logic signed [63:0] v);
        if (v > SAT_HI) begin
            run_fault = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO) begin
            run_fault = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] mul_q(input logic signed [63:0] x,
                                                 input logic signed [63:0] y);
        logic signed [63:0] p;
        p = x * y;
        return clamp_q(p >>> 16);
    endfunction

    // Elimination factor -x/y, truncated toward zero
    function automatic logic signed [63:0] neg_ratio_q(input logic signed [63:0] x,
                                                       input logic signed [63:0] y);
        logic signed [63:0] q;
        if (y == 0) begin
            run_fault = 1'b1;
            if (x > 0) return SAT_LO;
            if (x < 0) return SAT_HI;
            return 0;
        end
        q = (x * 64'sd65536) / y;
        return clamp_q(-q);
    endfunction

    // Store one row; on the last row of a run, sweep and queue the reduced rows
    function automatic void load_and_reduce(input t_in_row r);
        int n;
        int slot;
        logic signed [63:0] f;
        t_out_row o;
        n = rows_per_run;
        slot = loaded_rows;
        if (n == 0) n = 1;
        if (n > ROWS_MAX) n = ROWS_MAX;
        if (slot >= ROWS_MAX) slot = ROWS_MAX - 1;
        lower_rows[slot] = r.row_lower;
        diag_rows[slot]  = r.row_diag;
        upper_rows[slot] = r.row_upper;
        rhs_rows[slot]   = r.row_rhs;
        loaded_rows = slot + 1;
        if (loaded_rows < n) return;
        // forward sweep: drop the sub-diagonal into the first-row coupling
        for (int i = 2; i < n; i++) begin
            f = neg_ratio_q(lower_rows[i], diag_rows[i-1]);
            lower_rows[i] = mul_q(f, lower_rows[i-1]);
            diag_rows[i]  = clamp_q(diag_rows[i] + mul_q(f, upper_rows[i-1]));
            rhs_rows[i]   = clamp_q(rhs_rows[i] + mul_q(f, rhs_rows[i-1]));
        end
        // backward sweep: drop the super-diagonal into the last-row coupling
        for (int i = n - 3; i >= 0; i--) begin
            f = neg_ratio_q(upper_rows[i], diag_rows[i+1]);
            upper_rows[i] = mul_q(f, upper_rows[i+1]);
            rhs_rows[i]   = clamp_q(rhs_rows[i] + mul_q(f, rhs_rows[i+1]));
            if (i == 0)
                diag_rows[0] = clamp_q(diag_rows[0] + mul_q(f, lower_rows[1]));
            else
                lower_rows[i] = clamp_q(lower_rows[i] + mul_q(f, lower_rows[i+1]));
        end
        for (int k = 0; k < n; k++) begin
            o.out_lower    = lower_rows[k][31:0];
            o.out_diag     = diag_rows[k][31:0];
            o.out_upper    = upper_rows[k][31:0];
            o.out_rhs      = rhs_rows[k][31:0];
            o.last_row     = (k == n - 1);
            o.divide_fault = run_fault;
            reduced_rows_due.push_back(o);
        end
        loaded_rows = 0;
        run_fault = 1'b0;
        runs_done++;
    endfunction

    // Offer one row and wait for its transfer
    task automatic send_row(input t_in_row r);
        int gap;
        i_in_valid <= 1'b1;
        i_in_row   <= r;
        @(negedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
            @(negedge i_clk);
        end
        @(posedge i_clk);
        load_and_reduce(r);
        rows_sent++;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 18);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        while (reduced_rows_due.size() != 0) @(posedge i_clk);
    endtask

    // Write the row count once the block has gone idle
    task automatic set_row_count(input int value);
        i_in_valid <= 1'b0;
        drain_results();
        repeat (12) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CFG_W'(value);
        @(posedge i_clk);
        rows_per_run = value & 8'h7F;
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_in_row make_row(input logic signed [31:0] a,
                                         input logic signed [31:0] b,
                                         input logic signed [31:0] c,
                                         input logic signed [31:0] r);
        t_in_row t;
        t.row_lower = a;
        t.row_diag  = b;
        t.row_upper = c;
        t.row_rhs   = r;
        return t;
    endfunction

    function automatic t_in_row noise_row();
        return make_row($urandom, $urandom, $urandom, $urandom);
    endfunction

    // Diagonally dominant row with random content
    function automatic t_in_row sound_row();
        logic signed [31:0] b;
        b = $urandom_range(32'h0002_0000, 32'h0008_0000);
        if ($urandom_range(0, 1)) b = -b;
        return make_row($signed($urandom_range(0, 32'h0002_0000)) - ONE_Q, b,
                        $signed($urandom_range(0, 32'h0002_0000)) - ONE_Q,
                        $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endfunction

    // Check each transferred result against the oldest expected row
    always @(negedge i_clk) begin
        t_out_row want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (reduced_rows_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result row %h", o_out_row);
            end else begin
                want = reduced_rows_due.pop_front();
                rows_checked++;
                if (o_out_row !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("row %0d: expected a=%h b=%h c=%h r=%h last=%b flt=%b, got a=%h b=%h c=%h r=%h last=%b flt=%b",
                                 rows_checked, want.out_lower, want.out_diag,
                                 want.out_upper, want.out_rhs, want.last_row,
                                 want.divide_fault, o_out_row.out_lower,
                                 o_out_row.out_diag, o_out_row.out_upper,
                                 o_out_row.out_rhs, o_out_row.last_row,
                                 o_out_row.divide_fault);
                end
            end
        end
    end

    // Output stall: random bursts, plus one long hold on request
    always @(posedge i_clk) begin
        int burst;
        int hold_left;
        int hold_seen;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            burst = 0;
            hold_left = 0;
            hold_seen = 0;
        end else begin
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (burst > 0) begin
                burst--;
                i_out_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 18) - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Extreme fields on one-, two- and three-row runs, zero count as one row
    task automatic test_small_runs();
        set_row_count(1);
        send_row(make_row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF));
        send_row(make_row(32'sh7FFF_FFFF, 32'sh8000_0000, 32'shFFFF_FFFF, 32'sh0000_0000));
        set_row_count(0);
        send_row(make_row(32'sh0000_0000, 32'shFFFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
        set_row_count(2);
        send_row(make_row(ONE_Q, 32'sh0004_0000, -ONE_Q, 32'sh0003_8000));
        send_row(make_row(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000));
        set_row_count(3);
        send_row(make_row(ONE_Q, 32'sh0004_0000, -ONE_Q, 32'sh0001_0000));
        send_row(make_row(-ONE_Q, 32'shFFFB_0000, 32'sh0000_8000, 32'shFFFE_0000));
        send_row(make_row(32'sh0000_4000, 32'sh0003_0000, ONE_Q, 32'sh0007_0000));
        // saturating products
        send_row(make_row(32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_row(make_row(32'sh7FFF_FFFF, 32'sh0000_0001, 32'sh8000_0000, 32'sh8000_0000));
        send_row(make_row(32'sh8000_0000, 32'sh0000_0001, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    endtask

    // Zero divisors with negative and zero numerators
    task automatic test_zero_divisor();
        set_row_count(3);
        send_row(make_row(ONE_Q, 32'sh0000_0000, -ONE_Q, ONE_Q));
        send_row(make_row(ONE_Q, 32'sh0000_0000, ONE_Q, ONE_Q));
        send_row(make_row(-ONE_Q, ONE_Q, ONE_Q, ONE_Q));
        set_row_count(4);
        send_row(make_row(ONE_Q, 32'sh0002_0000, 32'sh0000_0000, ONE_Q));
        send_row(make_row(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, ONE_Q));
        send_row(make_row(32'sh0000_0000, 32'sh0002_0000, -ONE_Q, ONE_Q));
        send_row(make_row(ONE_Q, 32'sh0002_0000, ONE_Q, ONE_Q));
    endtask

    // Count lowered below the rows already loaded: next row completes the run
    task automatic test_count_cut_mid_load();
        set_row_count(8);
        for (int i = 0; i < 5; i++) send_row(sound_row());
        set_row_count(3);
        send_row(sound_row());
    endtask

    // Largest runs: 64 rows, and a count above the maximum acting as 64
    task automatic test_full_runs();
        set_row_count(64);
        for (int i = 0; i < 64; i++) send_row(sound_row());
        set_row_count(127);
        for (int i = 0; i < 64; i++) send_row(i % 9 == 4 ? noise_row() : sound_row());
    endtask

    // Long output hold while rows keep coming, so the input backs up
    task automatic test_output_backpressure();
        set_row_count(6);
        hold_seq++;
        for (int i = 0; i < 12; i++) send_row(sound_row());
    endtask

    // Random runs, mostly well-conditioned, some with noise rows
    task automatic test_random_runs(input int items);
        int n;
        int sent;
        sent = 0;
        while (sent < items) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 24) : $urandom_range(1, 8);
            set_row_count(n);
            for (int i = 0; i < n; i++) begin
                send_row($urandom_range(0, 6) == 0 ? noise_row() : sound_row());
                sent++;
            end
            if (sent > items / 2) quiet = 1'b1;
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_in_row     = '0;
        mismatches   = 0;
        rows_checked = 0;
        rows_sent    = 0;
        runs_done    = 0;
        quiet        = 1'b0;
        hold_seq     = 0;
        loaded_rows  = 0;
        run_fault    = 1'b0;
        rows_per_run = 64;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_small_runs();
        test_zero_divisor();
        test_count_cut_mid_load();
        test_output_backpressure();
        test_full_runs();
        test_random_runs(60);

        i_in_valid <= 1'b0;
        drain_results();
        repeat (200) @(posedge i_clk);
        $display("sent %0d rows in %0d runs, checked %0d reduced rows, %0d mismatches",
                 rows_sent, runs_done, rows_checked, mismatches);
        $display("covered counts 0..127, zero divisors, saturation, mid-load count change");
        if (mismatches == 0 && reduced_rows_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
